/* rtl/tbav_pkg.sv */
// Shared types and constants of the triple-buffer page flipper with A/V sync.
`default_nettype none

package tbav_pkg;

	// Field widths of the stream and configuration ports
	localparam int CMD_W     = 4;
	localparam int VAL_W     = 16;
	localparam int SR_W      = 16;
	localparam int FR_W      = 13;
	localparam int HT_W      = 8;
	localparam int CNT_W     = 32;
	localparam int OFF_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int OUT_W     = 96;

	// Sync math: audio scale factor and serial multiplier sizing
	localparam int SYNC_SCALE = 100;
	localparam int K_W        = 23;   // sample_rate * 100 fits in 23 bits
	localparam int HI_W       = 36;   // upper accumulator of the serial MAC
	localparam int STEP_W     = 5;    // counts K_W steps

	// Register reset values
	localparam logic [SR_W-1:0] SAMPLE_RATE_RST    = 16'd44100;
	localparam logic [FR_W-1:0] FRAME_RATE_RST     = 13'd1000;
	localparam logic [HT_W-1:0] PICTURE_HEIGHT_RST = 8'd192;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_DECODE_DONE = 4'd0,
		CMD_ADD_SAMPLES = 4'd1,
		CMD_VBLANK      = 4'd2,
		CMD_START       = 4'd3,
		CMD_RESET       = 4'd4,
		CMD_CLEAR_NEXT  = 4'd5,
		CMD_STOP        = 4'd6,
		CMD_RESUME      = 4'd7,
		CMD_SET_DELAY   = 4'd8
	} tbav_cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_RATE    = 2'd0,
		CFG_FRAME_RATE     = 2'd1,
		CFG_PICTURE_HEIGHT = 2'd2
	} tbav_cfg_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CALC = 2'd1,
		ST_DONE = 2'd2
	} tbav_state_t;

	// Status from the sync MAC back to the sequencer
	typedef struct packed {
		logic done;   // one-cycle pulse when the difference is known
		logic late;   // difference was strictly positive
	} tbav_mac_stat_t;

endpackage

`default_nettype wire

/* rtl/tbav_sync_mac.sv */
// Bit-serial multiply-accumulate that forms the sign of the A/V sync difference.
`default_nettype none

module tbav_sync_mac (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire  [tbav_pkg::CNT_W-1:0]     sample_total,
	input  wire  [tbav_pkg::CNT_W-1:0]     frame_diff,
	input  wire  [tbav_pkg::FR_W-1:0]      frame_rate,
	input  wire  [tbav_pkg::SR_W-1:0]      sample_rate,
	output tbav_pkg::tbav_mac_stat_t       stat
);
	import tbav_pkg::*;

	// D = sample_total*frame_rate - frame_diff*(sample_rate*100), one multiplier bit
	// per cycle, low product bits leave the accumulator and only their OR is kept.
	logic                   busy_q;
	logic [STEP_W-1:0]      step_q;
	logic [K_W-1:0]         fr_sh_q;
	logic [K_W-1:0]         k_sh_q;
	logic [CNT_W-1:0]       smp_q;
	logic [CNT_W-1:0]       dif_q;
	logic signed [HI_W-1:0] hi_q;
	logic                   sticky_q;
	logic                   done_q;
	logic                   late_q;

	logic signed [HI_W-1:0] add_smp;
	logic signed [HI_W-1:0] add_dif;
	logic signed [HI_W-1:0] sum;
	logic signed [HI_W-1:0] hi_nxt;
	logic                   sticky_nxt;
	logic [K_W-1:0]         k_load;

	assign k_load  = K_W'(sample_rate) * K_W'(SYNC_SCALE);
	assign add_smp = fr_sh_q[0] ? {{(HI_W-CNT_W){smp_q[CNT_W-1]}}, smp_q} : '0;
	assign add_dif = k_sh_q[0]  ? {{(HI_W-CNT_W){dif_q[CNT_W-1]}}, dif_q} : '0;
	assign sum        = hi_q + add_smp - add_dif;
	assign hi_nxt     = sum >>> 1;
	assign sticky_nxt = sticky_q | sum[0];

	// control of the step sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
			late_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(K_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					late_q <= !hi_nxt[HI_W-1] && ((hi_nxt != '0) || sticky_nxt);
				end
			end
		end
	end

	// operand shifters and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			fr_sh_q  <= K_W'(frame_rate);
			k_sh_q   <= k_load;
			smp_q    <= sample_total;
			dif_q    <= frame_diff;
			hi_q     <= '0;
			sticky_q <= 1'b0;
		end else if (busy_q) begin
			fr_sh_q  <= fr_sh_q >> 1;
			k_sh_q   <= k_sh_q >> 1;
			hi_q     <= hi_nxt;
			sticky_q <= sticky_nxt;
		end
	end

	assign stat.done = done_q;
	assign stat.late = late_q;

endmodule

`default_nettype wire

/* rtl/triple_buffer_av_sync_flipper.sv */
// Top level: page ring, command sequencer, status output register and sync MAC.
`default_nettype none

// Each beat on the slave side carries one command (tuser) and its argument (tdata)
// and yields exactly one status beat on the master side. For a command other than a
// running vblank, the sequencer goes from idle to its done state, the status register
// loads from the done state and the sequencer returns to idle, where the next beat
// can be taken. For a vblank while running, the sync difference is built by a
// bit-serial multiply-accumulate that consumes one bit of frame_rate and
// sample_rate*100 per cycle. Its done pulse moves the sequencer from the calculation
// state to the done state, from which the status register loads.
// A new beat is accepted while a finished status beat still waits on the master side.
// Its own status then waits in the done state until that register is free.
// Configuration writes are registered and must only be issued while idle.
module triple_buffer_av_sync_flipper #(
	parameter int PAGES        = 3,
	parameter int LINE_PIXELS  = 256,
	parameter int SCREEN_LINES = 192
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// command stream
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [tbav_pkg::VAL_W-1:0]         s_tdata,   // [15:0] value
	input  wire  [tbav_pkg::CMD_W-1:0]         s_tuser,   // [3:0] cmd
	// status stream
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// [0] flipped, [2:1] display_page, [4:3] decode_page, [20:5] decode_offset,
	// [22:21] frames_ready, [24:23] free_pages, [56:25] frames_shown,
	// [88:57] vblank_count, [89] running, [90] video_late, [95:91] zero
	output logic [tbav_pkg::OUT_W-1:0]         m_tdata,
	// configuration
	input  wire                                cfg_we,
	input  wire  [tbav_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  wire  [tbav_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
	import tbav_pkg::*;

	localparam int IDX_W = $clog2(PAGES + 1);
	localparam int PG_W  = $clog2(PAGES);
	localparam int GAP_W = 11;

	// page after p in the ring; "none" goes to page 0
	function automatic logic [IDX_W-1:0] page_after(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p >= IDX_W'(PAGES - 1)) r = '0;
		else r = p + IDX_W'(1);
		return r;
	endfunction

	// state
	tbav_state_t       state_q, state_nxt;
	logic [PAGES-1:0]  page_ready_q;
	logic [PG_W-1:0]   decode_idx_q;
	logic [IDX_W-1:0]  display_idx_q;
	logic [CNT_W-1:0]  sample_total_q;
	logic [CNT_W-1:0]  shown_q;
	logic [CNT_W-1:0]  vblank_q;
	logic [VAL_W-1:0]  delay_q;
	logic              run_q;
	logic              late_q;
	logic [SR_W-1:0]   sample_rate_q;
	logic [FR_W-1:0]   frame_rate_q;
	logic [HT_W-1:0]   picture_height_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [VAL_W-1:0]  value_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// next values when the current beat retires
	logic [PAGES-1:0]  nxt_ready;
	logic [IDX_W-1:0]  nxt_decode;
	logic [IDX_W-1:0]  nxt_display;
	logic [CNT_W-1:0]  nxt_samples;
	logic [CNT_W-1:0]  nxt_shown;
	logic [CNT_W-1:0]  nxt_vblank;
	logic [VAL_W-1:0]  nxt_delay;
	logic              nxt_run;
	logic              nxt_late;
	logic              nxt_flip;
	logic [IDX_W-1:0]  rc;
	logic [IDX_W-1:0]  free_cnt;
	logic [GAP_W-1:0]  line_gap;
	logic [CNT_W-1:0]  off_full;
	logic [OFF_W-1:0]  offset;
	logic [IDX_W-1:0]  decode_ext;

	logic              in_fire;
	logic              done_fire;
	logic              mac_start;
	logic [CNT_W-1:0]  frame_diff;
	tbav_mac_stat_t    mac_stat;

	assign in_fire   = s_tvalid && s_tready;
	assign done_fire = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign frame_diff = shown_q - {{(CNT_W-VAL_W){delay_q[VAL_W-1]}}, delay_q};
	assign decode_ext = IDX_W'(decode_idx_q);

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if ((tbav_cmd_t'(s_tuser) == CMD_VBLANK) && run_q) state_nxt = ST_CALC;
					else state_nxt = ST_DONE;
				end
			end
			ST_CALC: begin
				if (mac_stat.done) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (done_fire) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		mac_start = (state_q == ST_IDLE) && s_tvalid &&
		            (tbav_cmd_t'(s_tuser) == CMD_VBLANK) && run_q;
	end

	// command effect on the page ring and counters
	always_comb begin
		logic [IDX_W-1:0] nx;
		nxt_ready   = page_ready_q;
		nxt_decode  = decode_ext;
		nxt_display = display_idx_q;
		nxt_samples = sample_total_q;
		nxt_shown   = shown_q;
		nxt_vblank  = vblank_q;
		nxt_delay   = delay_q;
		nxt_run     = run_q;
		nxt_late    = late_q;
		nxt_flip    = 1'b0;
		nx          = page_after(display_idx_q);
		unique case (tbav_cmd_t'(cmd_q))
			CMD_DECODE_DONE: begin
				nxt_ready[decode_idx_q] = 1'b1;
				nxt_decode = page_after(decode_ext);
			end
			CMD_ADD_SAMPLES: begin
				nxt_samples = sample_total_q + {{(CNT_W-VAL_W){value_q[VAL_W-1]}}, value_q};
			end
			CMD_VBLANK: begin
				if (run_q) begin
					nxt_vblank = vblank_q + CNT_W'(1);
					nxt_late   = mac_stat.late;
					if (mac_stat.late && page_ready_q[nx[PG_W-1:0]]) begin
						if (display_idx_q < IDX_W'(PAGES))
							nxt_ready[display_idx_q[PG_W-1:0]] = 1'b0;
						nxt_display = nx;
						nxt_shown   = shown_q + CNT_W'(1);
						nxt_flip    = 1'b1;
					end
				end
			end
			CMD_START: begin
				nxt_samples = '0;
				nxt_shown   = '0;
				nxt_vblank  = '0;
				nxt_delay   = '0;
				nxt_run     = 1'b1;
				if (page_ready_q[nx[PG_W-1:0]]) begin
					if (display_idx_q < IDX_W'(PAGES))
						nxt_ready[display_idx_q[PG_W-1:0]] = 1'b0;
					nxt_display = nx;
					nxt_shown   = CNT_W'(1);
					nxt_flip    = 1'b1;
				end
			end
			CMD_RESET: begin
				nxt_decode  = '0;
				nxt_display = IDX_W'(PAGES);
				nxt_delay   = '0;
				nxt_samples = '0;
				nxt_shown   = '0;
				nxt_vblank  = '0;
				nxt_ready   = '0;
			end
			CMD_CLEAR_NEXT: begin
				nxt_samples = '0;
				nxt_shown   = '0;
				nxt_vblank  = '0;
				nxt_decode  = nx;
				for (int i = 0; i < PAGES; i++) begin
					if (IDX_W'(i) != display_idx_q) nxt_ready[i] = 1'b0;
				end
			end
			CMD_STOP:      nxt_run   = 1'b0;
			CMD_RESUME:    nxt_run   = 1'b1;
			CMD_SET_DELAY: nxt_delay = value_q;
			default: ;
		endcase
	end

	// ready page count and decode offset for the status beat
	always_comb begin
		rc = '0;
		for (int i = 0; i < PAGES; i++) rc = rc + IDX_W'(nxt_ready[i]);
		free_cnt = IDX_W'(PAGES) - rc;
		line_gap = GAP_W'(SCREEN_LINES) - GAP_W'(picture_height_q);
		off_full = CNT_W'(line_gap) * CNT_W'(LINE_PIXELS);
		if (GAP_W'(picture_height_q) >= GAP_W'(SCREEN_LINES)) offset = '0;
		else offset = off_full[OFF_W-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			page_ready_q     <= '0;
			decode_idx_q     <= '0;
			display_idx_q    <= IDX_W'(PAGES);
			sample_total_q   <= '0;
			shown_q          <= '0;
			vblank_q         <= '0;
			delay_q          <= '0;
			run_q            <= 1'b0;
			late_q           <= 1'b0;
			m_tvalid_q       <= 1'b0;
			sample_rate_q    <= SAMPLE_RATE_RST;
			frame_rate_q     <= FRAME_RATE_RST;
			picture_height_q <= PICTURE_HEIGHT_RST;
		end else begin
			state_q <= state_nxt;
			if (done_fire) begin
				page_ready_q   <= nxt_ready;
				decode_idx_q   <= nxt_decode[PG_W-1:0];
				display_idx_q  <= nxt_display;
				sample_total_q <= nxt_samples;
				shown_q        <= nxt_shown;
				vblank_q       <= nxt_vblank;
				delay_q        <= nxt_delay;
				run_q          <= nxt_run;
				late_q         <= nxt_late;
				m_tvalid_q     <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (tbav_cfg_t'(cfg_addr))
					CFG_SAMPLE_RATE:    sample_rate_q    <= cfg_wdata[SR_W-1:0];
					CFG_FRAME_RATE:     frame_rate_q     <= cfg_wdata[FR_W-1:0];
					CFG_PICTURE_HEIGHT: picture_height_q <= cfg_wdata[HT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// command beat and status beat payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= s_tuser;
			value_q <= s_tdata;
		end
		if (done_fire) begin
			m_tdata_q <= {5'b0, nxt_late, nxt_run, nxt_vblank, nxt_shown,
			              free_cnt[1:0], rc[1:0], offset,
			              nxt_decode[1:0], nxt_display[1:0], nxt_flip};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	tbav_sync_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mac_start),
		.sample_total (sample_total_q),
		.frame_diff   (frame_diff),
		.frame_rate   (frame_rate_q),
		.sample_rate  (sample_rate_q),
		.stat         (mac_stat)
	);

	// checks
	a_display_range: assert property (@(posedge clk) disable iff (!arst_n)
		display_idx_q <= IDX_W'(PAGES))
		else $error("display page index out of range");

	a_mac_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> state_q == ST_CALC)
		else $error("sync result arrived outside calculation");

	a_flip_shows_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && nxt_flip) |=> page_ready_q[display_idx_q[PG_W-1:0]])
		else $error("flipped to a page that is not ready");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != ST_IDLE)
		else $error("accepted beat did not start processing");

endmodule

`default_nettype wire

/* dv/tbav_status_checker.sv */
// Checker for the page flipper: predicts each status beat and compares it with the DUT output.
module tbav_status_checker #(
	parameter int PAGES        = 3,
	parameter int LINE_PIXELS  = 256,
	parameter int SCREEN_LINES = 192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [tbav_pkg::VAL_W-1:0]     s_tdata,   // [15:0] value
	input  logic [tbav_pkg::CMD_W-1:0]     s_tuser,   // [3:0] cmd
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] flipped, [2:1] display_page, [4:3] decode_page, [20:5] decode_offset,
	// [22:21] frames_ready, [24:23] free_pages, [56:25] frames_shown,
	// [88:57] vblank_count, [89] running, [90] video_late, [95:91] zero
	input  logic [tbav_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           cfg_we,
	input  logic [tbav_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [tbav_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output int                             fail_count,
	output int                             pending,
	output int                             checked,
	output int                             flips
);
	timeunit 1ns;
	timeprecision 1ps;

	import tbav_pkg::*;

	// One status beat, in the field order of m_tdata
	typedef struct packed {
		logic        late;
		logic        running;
		logic [31:0] vblanks;
		logic [31:0] shown;
		logic [1:0]  free;
		logic [1:0]  ready;
		logic [15:0] offset;
		logic [1:0]  decode;
		logic [1:0]  display;
		logic        flipped;
	} status_t;

	// Shadow of the player state
	logic        page_full [PAGES];
	int unsigned write_pg;
	int unsigned show_pg;
	logic [31:0] audio_sum;
	logic [31:0] shown_cnt;
	logic [31:0] vbl_cnt;
	logic [15:0] av_delay;
	logic        playing;
	logic        behind;

	// Shadow of the registers
	logic [SR_W-1:0] rate_hz;
	logic [FR_W-1:0] rate_fps;
	logic [HT_W-1:0] lines_used;

	status_t status_due [$];
	int      err_tally;
	int      beats_seen;
	int      flip_tally;

	function automatic int unsigned page_after(int unsigned p);
		if (p >= PAGES)
			return 0;
		return (p + 1 >= PAGES) ? 0 : p + 1;
	endfunction

	function automatic int unsigned pages_ready();
		int unsigned n;
		n = 0;
		for (int i = 0; i < PAGES; i++)
			n += page_full[i];
		return n;
	endfunction

	// Move the display to the next page if it is ready; the first page frees nothing
	function automatic logic advance_display();
		int unsigned nx;
		nx = page_after(show_pg);
		if (!page_full[nx])
			return 1'b0;
		if (show_pg < PAGES)
			page_full[show_pg] = 1'b0;
		show_pg = nx;
		return 1'b1;
	endfunction

	// Apply one command to the shadow state and build the status it reports
	function automatic status_t predict_status(logic [CMD_W-1:0] code, logic [VAL_W-1:0] arg);
		status_t     st;
		logic        flip;
		logic [31:0] lag32;
		longint      lag;
		longint      sync_diff;
		int unsigned n;
		flip = 1'b0;
		case (code)
			CMD_DECODE_DONE: begin
				if (write_pg < PAGES)
					page_full[write_pg] = 1'b1;
				write_pg = page_after(write_pg);
			end
			CMD_ADD_SAMPLES: begin
				audio_sum = audio_sum + {{16{arg[15]}}, arg};
			end
			CMD_VBLANK: begin
				if (playing) begin
					vbl_cnt = vbl_cnt + 1;
					lag32 = shown_cnt - {{16{av_delay[15]}}, av_delay};
					lag = longint'($signed(lag32));
					sync_diff = longint'($signed(audio_sum)) * longint'(rate_fps)
						- lag * longint'(rate_hz) * SYNC_SCALE;
					behind = sync_diff > 0;
					if (sync_diff > 0 && pages_ready() > 0 && advance_display()) begin
						shown_cnt = shown_cnt + 1;
						flip = 1'b1;
					end
				end
			end
			CMD_START: begin
				audio_sum = '0;
				shown_cnt = '0;
				vbl_cnt = '0;
				av_delay = '0;
				if (pages_ready() > 0 && advance_display()) begin
					shown_cnt = shown_cnt + 1;
					flip = 1'b1;
				end
				playing = 1'b1;
			end
			CMD_RESET: begin
				write_pg = 0;
				show_pg = PAGES;
				av_delay = '0;
				audio_sum = '0;
				shown_cnt = '0;
				vbl_cnt = '0;
				for (int i = 0; i < PAGES; i++)
					page_full[i] = 1'b0;
			end
			CMD_CLEAR_NEXT: begin
				audio_sum = '0;
				shown_cnt = '0;
				vbl_cnt = '0;
				write_pg = page_after(show_pg);
				for (int i = 0; i < PAGES; i++)
					if (i != show_pg)
						page_full[i] = 1'b0;
			end
			CMD_STOP: playing = 1'b0;
			CMD_RESUME: playing = 1'b1;
			CMD_SET_DELAY: av_delay = arg;
			default: ;
		endcase

		n = pages_ready();
		st.flipped = flip;
		st.display = 2'(show_pg);
		st.decode = 2'(write_pg);
		st.offset = (lines_used >= SCREEN_LINES) ? 16'd0
			: 16'((SCREEN_LINES - lines_used) * LINE_PIXELS);
		st.ready = 2'(n);
		st.free = 2'(PAGES - n);
		st.shown = shown_cnt;
		st.vblanks = vbl_cnt;
		st.running = playing;
		st.late = behind;
		return st;
	endfunction

	function automatic void check_field(string label, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", label, want, got);
			err_tally++;
		end
	endfunction

	// Track the command and status channels at every edge
	always @(posedge clk or negedge arst_n) begin : watch
		status_t want;
		if (!arst_n) begin
			for (int i = 0; i < PAGES; i++)
				page_full[i] = 1'b0;
			write_pg = 0;
			show_pg = PAGES;
			audio_sum = '0;
			shown_cnt = '0;
			vbl_cnt = '0;
			av_delay = '0;
			playing = 1'b0;
			behind = 1'b0;
			rate_hz = SAMPLE_RATE_RST;
			rate_fps = FRAME_RATE_RST;
			lines_used = PICTURE_HEIGHT_RST;
			status_due.delete();
			err_tally = 0;
			beats_seen = 0;
			flip_tally = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_addr)
					CFG_SAMPLE_RATE:    rate_hz = cfg_wdata[SR_W-1:0];
					CFG_FRAME_RATE:     rate_fps = cfg_wdata[FR_W-1:0];
					CFG_PICTURE_HEIGHT: lines_used = cfg_wdata[HT_W-1:0];
					default: ;
				endcase
			end

			// status beat against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (status_due.size() == 0) begin
					$error("status beat arrived with no command outstanding");
					err_tally++;
				end else begin
					want = status_due.pop_front();
					check_field("flipped", want.flipped, m_tdata[0]);
					check_field("display_page", want.display, m_tdata[2:1]);
					check_field("decode_page", want.decode, m_tdata[4:3]);
					check_field("decode_offset", want.offset, m_tdata[20:5]);
					check_field("frames_ready", want.ready, m_tdata[22:21]);
					check_field("free_pages", want.free, m_tdata[24:23]);
					check_field("frames_shown", want.shown, m_tdata[56:25]);
					check_field("vblank_count", want.vblanks, m_tdata[88:57]);
					check_field("running", want.running, m_tdata[89]);
					check_field("video_late", want.late, m_tdata[90]);
					check_field("padding", 0, m_tdata[95:91]);
					beats_seen++;
					if (want.flipped)
						flip_tally++;
				end
			end

			// command beat: predict its status
			if (s_tvalid && s_tready)
				status_due.push_back(predict_status(s_tuser, s_tdata));
		end
		fail_count <= err_tally;
		pending <= status_due.size();
		checked <= beats_seen;
		flips <= flip_tally;
	end

endmodule

/* dv/triple_buffer_av_sync_flipper_test.sv */
// Testbench top: clock, reset, command and register stimulus, status sink and verdict.
module triple_buffer_av_sync_flipper_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tbav_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTINGS_COUNT = 8;
	localparam int RAND_PER_PHASE = 128;
	localparam int IDLE_LIMIT     = 2000;
	localparam int PHASE_SETTLE   = 6;
	localparam int END_SETTLE     = 40;

	// Command codes the block does not define
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [VAL_W-1:0]     s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int checked;
	int flips;

	int sent;
	int burst_left;
	int idle_cycles;
	int rx_left;
	int rate_hz;
	int rate_fps;
	int lines_used;
	int per_frame;
	int pick;
	int delta;
	logic [CMD_W-1:0] code;
	logic [VAL_W-1:0] arg;

	always #(CLK_PERIOD / 2) clk = ~clk;

	triple_buffer_av_sync_flipper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	tbav_status_checker u_status_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.flips      (flips)
	);

	// Status sink: alternating ready runs and stalls, with occasional long open stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_left <= 0;
		end else if (rx_left != 0) begin
			rx_left <= rx_left - 1;
		end else if (m_tready) begin
			m_tready <= 1'b0;
			rx_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14)
				: $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
			rx_left <= ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 24);
		end
	end

	// Watchdog: ends the run if no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Send one command beat; returns at the edge that accepted it, or after a random idle gap behind it
	task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] val);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= val;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait until every status beat has come back
	task automatic drain(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write all three registers back to back
	task automatic load_settings(input int sr, input int fr, input int ht);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_SAMPLE_RATE;
		cfg_wdata <= CFG_DAT_W'(sr);
		@(posedge clk);
		cfg_addr <= CFG_FRAME_RATE;
		cfg_wdata <= CFG_DAT_W'(fr);
		@(posedge clk);
		cfg_addr <= CFG_PICTURE_HEIGHT;
		cfg_wdata <= CFG_DAT_W'(ht);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		sent = 0;
		burst_left = 1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stopped vblank, unknown codes, first flip, ring wrap, delay extremes
		push_cmd(CMD_VBLANK, 16'h0000);
		push_cmd(CMD_UNUSED_LO, 16'hFFFF);
		push_cmd(CMD_UNUSED_HI, 16'h0000);
		push_cmd(CMD_DECODE_DONE, 16'h0000);
		push_cmd(CMD_START, 16'h0000);
		push_cmd(CMD_DECODE_DONE, 16'h0000);
		push_cmd(CMD_DECODE_DONE, 16'h0000);
		push_cmd(CMD_DECODE_DONE, 16'h0000);
		push_cmd(CMD_ADD_SAMPLES, 16'h7FFF);
		push_cmd(CMD_ADD_SAMPLES, 16'h8000);
		push_cmd(CMD_VBLANK, 16'h0000);
		push_cmd(CMD_ADD_SAMPLES, 16'h7FFF);
		push_cmd(CMD_VBLANK, 16'h0000);
		push_cmd(CMD_SET_DELAY, 16'h7FFF);
		push_cmd(CMD_VBLANK, 16'h0000);
		push_cmd(CMD_SET_DELAY, 16'h8000);
		push_cmd(CMD_VBLANK, 16'h0000);
		push_cmd(CMD_STOP, 16'h0000);
		push_cmd(CMD_VBLANK, 16'h0000);
		push_cmd(CMD_RESUME, 16'h0000);
		push_cmd(CMD_CLEAR_NEXT, 16'h0000);
		push_cmd(CMD_DECODE_DONE, 16'h0000);
		push_cmd(CMD_RESET, 16'h0000);
		push_cmd(CMD_VBLANK, 16'h0000);
		push_cmd(CMD_DECODE_DONE, 16'h0000);
		push_cmd(CMD_ADD_SAMPLES, 16'h0064);
		push_cmd(CMD_VBLANK, 16'h0000);

		// Random play sessions, one per register setting
		for (int ph = 0; ph < SETTINGS_COUNT; ph++) begin
			case (ph)
				0: begin rate_hz = 44100; rate_fps = 1000; lines_used = 192; end
				1: begin rate_hz = 44100; rate_fps = 1000; lines_used = 192; end
				2: begin rate_hz = 65535; rate_fps = 6000; lines_used = 0; end
				3: begin rate_hz = 1; rate_fps = 1; lines_used = 255; end
				4: begin rate_hz = 48000; rate_fps = 2997; lines_used = 120; end
				5: begin rate_hz = 0; rate_fps = 0; lines_used = 193; end
				6: begin rate_hz = 65535; rate_fps = 8191; lines_used = 64; end
				default: begin rate_hz = 22050; rate_fps = 2500; lines_used = 191; end
			endcase
			if (ph != 0) begin
				drain(PHASE_SETTLE);
				load_settings(rate_hz, rate_fps, lines_used);
				push_cmd(CMD_START, 16'h0000);
			end
			per_frame = (rate_fps == 0) ? 2000 : rate_hz * 100 / rate_fps;
			if (per_frame < 1)
				per_frame = 1;
			if (per_frame > 16000)
				per_frame = 16000;

			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				arg = 16'($urandom_range(0, 65535));
				if (pick < 30) begin
					code = CMD_DECODE_DONE;
				end else if (pick < 55) begin
					code = CMD_ADD_SAMPLES;
					// mostly about one frame of audio, sometimes any value
					if ($urandom_range(0, 7) != 0)
						arg = 16'($urandom_range(0, 2 * per_frame));
				end else if (pick < 85) begin
					code = CMD_VBLANK;
				end else if (pick < 88) begin
					code = CMD_START;
				end else if (pick < 90) begin
					code = CMD_RESET;
				end else if (pick < 92) begin
					code = CMD_CLEAR_NEXT;
				end else if (pick < 94) begin
					code = CMD_STOP;
				end else if (pick < 96) begin
					code = CMD_RESUME;
				end else if (pick < 98) begin
					code = CMD_SET_DELAY;
					// small signed delays most of the time
					if ($urandom_range(0, 3) != 0) begin
						delta = int'($urandom_range(0, 8)) - 4;
						arg = 16'(delta);
					end
				end else begin
					code = CMD_UNUSED_LO + CMD_W'($urandom_range(0, CMD_UNUSED_HI - CMD_UNUSED_LO));
				end
				push_cmd(code, arg);
			end
		end

		drain(END_SETTLE);
		$display("Sent %0d commands over %0d register settings, mixed sender gaps and sink stalls",
			sent, SETTINGS_COUNT);
		$display("Checked %0d status beats, %0d of them with a page flip", checked, flips);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/tbav_pkg.sv
rtl/tbav_sync_mac.sv
rtl/triple_buffer_av_sync_flipper.sv
dv/tbav_status_checker.sv
dv/triple_buffer_av_sync_flipper_test.sv
